[design/rau_pkg.sv]
// Package for the rational arithmetic unit: action codes and shared types.
// No dependencies.
package rau_pkg;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_LT  = 3'd4,
    ACT_GT  = 3'd5,
    ACT_EQ  = 3'd6,
    ACT_NOP = 3'd7
  } action_t;

  // control between sequencer and divider
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

[design/rau_div.sv]
// Shared iterative truncating divider, one quotient bit per cycle.
// Depends on rau_pkg.
module rau_div #(
  parameter int WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rau_pkg::div_req_t   req,
  input  logic [WIDTH-1:0]    dividend,
  input  logic [WIDTH-1:0]    divisor,
  output rau_pkg::div_sts_t   sts,
  output logic [WIDTH-1:0]    quo,
  output logic [WIDTH-1:0]    rem
);
  import rau_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] q_r, q_nxt, d_r, d_nxt;
  logic [WIDTH:0]   p_r, p_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt, qneg_r, qneg_nxt, rneg_r, rneg_nxt;
  logic [WIDTH:0]   shifted, diff;

  // magnitudes held as WIDTH-bit unsigned; most negative is fine unsigned
  always_comb begin
    q_nxt = q_r; d_nxt = d_r; p_nxt = p_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0; qneg_nxt = qneg_r; rneg_nxt = rneg_r;
    shifted = {p_r[WIDTH-1:0], q_r[WIDTH-1]};
    diff = shifted - {1'b0, d_r};
    if (req.start) begin
      q_nxt = dividend[WIDTH-1] ? -dividend : dividend;
      d_nxt = divisor[WIDTH-1] ? -divisor : divisor;
      p_nxt = '0;
      cnt_nxt = CW'(WIDTH);
      busy_nxt = 1'b1;
      qneg_nxt = dividend[WIDTH-1] ^ divisor[WIDTH-1];
      rneg_nxt = dividend[WIDTH-1];
    end else if (busy_r) begin
      // restoring step
      if (!diff[WIDTH]) begin
        p_nxt = diff;
        q_nxt = {q_r[WIDTH-2:0], 1'b1};
      end else begin
        p_nxt = shifted;
        q_nxt = {q_r[WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt; d_r <= d_nxt; p_r <= p_nxt; qneg_r <= qneg_nxt; rneg_r <= rneg_nxt;
  end

  assign quo = qneg_r ? -q_r : q_r;
  assign rem = rneg_r ? -p_r[WIDTH-1:0] : p_r[WIDTH-1:0];
  assign sts.busy = busy_r;
  assign sts.done = done_r;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without busy");
  a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(done_r && busy_r)) else $error("done while busy");
`endif
endmodule

[design/rational_arithmetic_unit_top.sv]
// Top level of the rational arithmetic unit: sequencer, shared multiplier,
// Euclid loop on the shared divider (rau_div). Depends on rau_pkg.
//
// One beat in, one beat out. Multiply, divide and compare actions form three
// products through one registered multiplier. Add and subtract then run
// Euclid's algorithm on the shared bit-serial divider, one remainder step per
// division and up to about 46 steps at 32 bits, followed by two more divisions
// for the reduction before the result beat. in_tready is high only while the
// unit is idle; the result waits in an output register and the next beat is
// accepted once it is taken.
module rational_arithmetic_unit_top #(
  parameter int WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
  input  logic [127:0] in_tdata,
  // tuser: action[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: res_num[31:0], res_den[63:32], cmp_true[64], reduce_error[65], zeros
  output logic [71:0]  out_tdata
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_P1, S_P2, S_P3, S_DEC, S_GSTART, S_GWAIT,
    S_RDEN, S_RDENW, S_RNUM, S_RNUMW, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0]       act_r, act_nxt;
  logic [WIDTH-1:0] an_r, ad_r, bn_r, bd_r, an_nxt, ad_nxt, bn_nxt, bd_nxt;
  logic [WIDTH-1:0] p1_r, p2_r, p1_nxt, p2_nxt;
  logic [WIDTH-1:0] num_r, den_r, num_nxt, den_nxt;
  logic [WIDTH-1:0] ga_r, gb_r, ga_nxt, gb_nxt;
  logic             cmp_r, cmp_nxt, err_r, err_nxt;
  logic [WIDTH-1:0] ma, mb, prod_r;
  logic [WIDTH-1:0] prod_full;
  logic [WIDTH-1:0] dvd, dvs, quo, rem, g;
  div_req_t         dreq;
  div_sts_t         dsts;

  function automatic logic [WIDTH-1:0] trunc(input logic [31:0] x);
    logic [63:0] e;
    e = 64'($signed(x));
    return e[WIDTH-1:0];
  endfunction

  function automatic logic [31:0] ext32(input logic [WIDTH-1:0] x);
    logic [63:0] e;
    e = 64'($signed(x));
    return e[31:0];
  endfunction

  // shared multiplier, operands picked by state
  // multiply: an*bn, bn*ad (unused), then ad*bd; others: an*bd, bn*ad, then ad*bd or ad*bn
  always_comb begin
    ma = an_r; mb = bd_r;
    case (state_r)
      S_P1: begin ma = an_r; mb = (act_r == ACT_MUL) ? bn_r : bd_r; end
      S_P2: begin ma = bn_r; mb = ad_r; end
      S_P3: begin ma = ad_r; mb = (act_r == ACT_DIV) ? bn_r : bd_r; end
      default: begin ma = an_r; mb = bd_r; end
    endcase
  end
  assign prod_full = ma * mb;

  assign g = ga_r + gb_r;
  assign dreq.start = (state_r == S_GSTART && ga_r != '0 && gb_r != '0)
                      || state_r == S_RDEN || state_r == S_RNUM;
  always_comb begin
    dvd = ga_r; dvs = gb_r;
    case (state_r)
      S_RDEN: begin dvd = den_r; dvs = ga_r; end
      S_RNUM: begin dvd = num_r; dvs = ga_r; end
      default: begin dvd = ga_r; dvs = gb_r; end
    endcase
  end

  rau_div #(.WIDTH(WIDTH)) u_div (
    .clk(clk), .rst_n(rst_n), .req(dreq), .dividend(dvd), .divisor(dvs),
    .sts(dsts), .quo(quo), .rem(rem)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r; act_nxt = act_r;
    an_nxt = an_r; ad_nxt = ad_r; bn_nxt = bn_r; bd_nxt = bd_r;
    p1_nxt = p1_r; p2_nxt = p2_r; num_nxt = num_r; den_nxt = den_r;
    ga_nxt = ga_r; gb_nxt = gb_r; cmp_nxt = cmp_r; err_nxt = err_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt = in_tuser;
          an_nxt = trunc(in_tdata[31:0]);
          ad_nxt = trunc(in_tdata[63:32]);
          bn_nxt = trunc(in_tdata[95:64]);
          bd_nxt = trunc(in_tdata[127:96]);
          state_nxt = S_P1;
        end
      end
      S_P1: state_nxt = S_P2;
      S_P2: begin p1_nxt = prod_r; state_nxt = S_P3; end
      S_P3: begin p2_nxt = prod_r; state_nxt = S_DEC; end
      S_DEC: begin
        num_nxt = '0; den_nxt = '0; cmp_nxt = 1'b0; err_nxt = 1'b0;
        state_nxt = S_OUT;
        case (act_r)
          ACT_ADD, ACT_SUB: begin
            num_nxt = (act_r == ACT_ADD) ? p1_r + p2_r : p1_r - p2_r;
            den_nxt = prod_r;
            ga_nxt = prod_r;
            gb_nxt = (act_r == ACT_ADD) ? p1_r + p2_r : p1_r - p2_r;
            state_nxt = S_GSTART;
          end
          ACT_MUL: begin num_nxt = p1_r; den_nxt = prod_r; end
          ACT_DIV: begin num_nxt = p1_r; den_nxt = prod_r; end
          ACT_LT:  cmp_nxt = $signed(p1_r) < $signed(p2_r);
          ACT_GT:  cmp_nxt = $signed(p1_r) > $signed(p2_r);
          ACT_EQ:  cmp_nxt = p1_r == p2_r;
          default: ;
        endcase
      end
      S_GSTART: begin
        if (ga_r == '0 || gb_r == '0) begin
          ga_nxt = g;
          if (g == '0) begin
            err_nxt = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_RDEN;
          end
        end else begin
          state_nxt = S_GWAIT;
        end
      end
      S_GWAIT: begin
        if (dsts.done) begin
          ga_nxt = gb_r;
          gb_nxt = rem;
          state_nxt = S_GSTART;
        end
      end
      S_RDEN: state_nxt = S_RDENW;
      S_RDENW: if (dsts.done) begin den_nxt = quo; state_nxt = S_RNUM; end
      S_RNUM: state_nxt = S_RNUMW;
      S_RNUMW: if (dsts.done) begin num_nxt = quo; state_nxt = S_OUT; end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    act_r <= act_nxt; an_r <= an_nxt; ad_r <= ad_nxt; bn_r <= bn_nxt; bd_r <= bd_nxt;
    p1_r <= p1_nxt; p2_r <= p2_nxt; num_r <= num_nxt; den_r <= den_nxt;
    ga_r <= ga_nxt; gb_r <= gb_nxt; cmp_r <= cmp_nxt; err_r <= err_nxt;
    prod_r <= prod_full;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {6'd0, err_r, cmp_r, ext32(den_r), ext32(num_r)};

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("ready while busy");
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GSTART || state_r == S_RDEN || state_r == S_RNUM) |-> !dsts.busy)
    else $error("divider busy at launch");
  a_err_only_arith: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && err_r) |-> (act_r == ACT_ADD || act_r == ACT_SUB))
    else $error("reduce error on non-arith action");
  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && cmp_r) |-> (num_r == '0 && den_r == '0))
    else $error("compare result with nonzero fraction");
`endif
endmodule
